// ----- hw/rtl/sc_pkg.sv -----
package sc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 2;
  localparam int LINES      = 2 * MAX_RADIUS + 1;
  localparam int LINE_DEPTH = LINES * MAX_WIDTH;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int RAD_W      = 2;
  localparam int COEF_W     = 16;
  localparam int HSUM_W     = 27;
  localparam int VPROD_W    = 43;
  localparam int VACC_W     = 46;
  localparam int FILT_W     = 20;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int NTAPS      = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 4'd0,
    REG_WIDTH  = 4'd1,
    REG_HEIGHT = 4'd2,
    REG_COEF0  = 4'd3,
    REG_COEF1  = 4'd4,
    REG_COEF2  = 4'd5,
    REG_COEF3  = 4'd6,
    REG_COEF4  = 4'd7
  } cfg_reg_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HSUM,
    S_CHECK,
    S_VRD,
    S_VACC,
    S_LAST,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // row modulo line count via reciprocal multiply, exact for 12-bit rows
  function automatic logic [2:0] mod_lines(input logic [ROW_W-1:0] x);
    logic [23:0] p;
    logic [9:0]  q;
    logic [12:0] r;
    p = 24'(x) * 24'd3277;
    q = p[23:14];
    r = 13'(x) - 13'(q) * 13'd5;
    return r[2:0];
  endfunction

endpackage

// ----- hw/rtl/sc_in_if.sv -----
interface sc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [sc_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output req_type, output pixel, input ready);
  modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

// ----- hw/rtl/sc_out_if.sv -----
interface sc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sc_pkg::FILT_W-1:0]  filtered;
  logic                              saturated;
  logic                              last_in_run;
  logic                              end_of_frame;

  modport source (output valid, output filtered, output saturated, output last_in_run,
                  output end_of_frame, input ready);
  modport sink   (input valid, input filtered, input saturated, input last_in_run,
                  input end_of_frame, output ready);
endinterface

// ----- hw/rtl/separable_conv_clamped_border_top.sv -----
// separable convolution with clamped borders over a raster pixel stream
// in_i carries words of req_type and pixel: a pixel word feeds the next
// pixel of the frame, a drain word releases one pending result
// out_o carries filtered (signed, 8 fraction bits, saturated), saturated,
// last_in_run and end_of_frame; a pixel word gives up to three results and
// a drain word up to one, the final one of a word flagged by last_in_run
// registers are written on cfg_we_i at index cfg_idx_i; the user must
// write them only while the block idles, the block does not enforce it;
// one word at a time: a pixel word is accepted, then each horizontal sum
// it writes (at most one at mid row, up to radius+1 at a row end) is
// accumulated tap by tap, then a check state follows (a drain word goes
// straight to it); each result is then read and accumulated tap by tap
// on the line store read port, then the last flag and output states follow
// the window row is a chain of five pixel cells
// reset clears counters, window, frame and last flags and loads default registers; the
// line store is not cleared
// a stalled receiver holds the result word and no new word is accepted
module separable_conv_clamped_border_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  sc_in_if.sink                           in_i,
  sc_out_if.source                        out_o
);
  import sc_pkg::*;

  // configuration registers
  logic [RAD_W-1:0]         radius_q;
  logic [WIDTH_W-1:0]       width_q;
  logic [HEIGHT_W-1:0]      height_q;
  logic signed [COEF_W-1:0] coef_q [NTAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= 2'd1;
      width_q   <= 11'd1024;
      height_q  <= 13'd1024;
      coef_q[0] <= 16'sd0;
      coef_q[1] <= 16'sd4096;
      coef_q[2] <= 16'sd8192;
      coef_q[3] <= 16'sd4096;
      coef_q[4] <= 16'sd0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_RADIUS: radius_q  <= cfg_data_i[RAD_W-1:0];
        REG_WIDTH:  width_q   <= cfg_data_i[WIDTH_W-1:0];
        REG_HEIGHT: height_q  <= cfg_data_i[HEIGHT_W-1:0];
        REG_COEF0:  coef_q[0] <= cfg_data_i;
        REG_COEF1:  coef_q[1] <= cfg_data_i;
        REG_COEF2:  coef_q[2] <= cfg_data_i;
        REG_COEF3:  coef_q[3] <= cfg_data_i;
        REG_COEF4:  coef_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes, clamped into their legal ranges
  logic [RAD_W-1:0]    eff_r;
  logic [WIDTH_W-1:0]  eff_w, wm1;
  logic [HEIGHT_W-1:0] eff_h, hm1;

  always_comb begin
    eff_r = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
    if (width_q == '0) begin
      eff_w = 11'd1;
    end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = 13'd1;
    end else if (height_q > 13'd4096) begin
      eff_h = 13'd4096;
    end else begin
      eff_h = height_q;
    end
    wm1 = eff_w - 11'd1;
    hm1 = eff_h - 13'd1;
  end

  // control and datapath registers
  state_e                state_q, state_d;
  logic [ROW_W-1:0]      in_row_q, out_row_q;
  logic [COL_W-1:0]      in_col_q, out_col_q;
  logic                  frame_done_q;
  logic [COL_W-1:0]      ic_q, hc_q, hc_hi_q;
  logic [2:0]            slot_q;
  logic [2:0]            t_q;
  logic [1:0]            n_q, limit_q;
  logic signed [HSUM_W-1:0] hacc_q;
  logic signed [VACC_W-1:0] vacc_q;
  logic signed [FILT_W-1:0] filt_q;
  logic                  sat_q, last_q, eof_q;

  // window cells
  logic [PIX_W-1:0] win [LINES];
  cell_ctrl_t       cell_ctrl;

  for (genvar k = 0; k < LINES; k++) begin : g_cell
    logic [PIX_W-1:0] prev;
    if (k == 0) begin : g_head
      assign prev = in_i.pixel;
    end else begin : g_link
      assign prev = win[k-1];
    end
    sc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .px_i   (in_i.pixel),
      .prev_i (prev),
      .pix_o  (win[k])
    );
  end

  // input position, clamped after size changes
  logic [ROW_W-1:0] ir;
  logic [COL_W-1:0] ic;
  logic             ic_end, ir_end, has_write, frame_start;
  logic [COL_W-1:0] hc_start, hc_last;

  always_comb begin
    ir = ({1'b0, in_row_q} < eff_h) ? in_row_q : hm1[ROW_W-1:0];
    ic = ({1'b0, in_col_q} < eff_w) ? in_col_q : wm1[COL_W-1:0];
    ic_end = ({1'b0, ic} == wm1);
    ir_end = ({1'b0, ir} == hm1);
    hc_start  = (ic >= COL_W'(eff_r)) ? (ic - COL_W'(eff_r)) : '0;
    has_write = ic_end || (ic >= COL_W'(eff_r));
    hc_last   = ic_end ? ic : hc_start;
    frame_start = (in_row_q == '0) && (in_col_q == '0);
  end

  logic [2:0] t_start, t_end;
  assign t_start = 3'd2 - 3'(eff_r);
  assign t_end   = 3'd2 + 3'(eff_r);

  // horizontal tap: window index clamped into the cell row
  logic [1:0]               hd;
  logic signed [3:0]        he;
  logic [2:0]               hk;
  logic signed [24:0]       hprod;
  logic signed [HSUM_W-1:0] hacc_d;

  always_comb begin
    hd = 2'(ic_q - hc_q);
    he = $signed({2'b00, hd}) + 4'sd2 - $signed({1'b0, t_q});
    if (he < 4'sd0) begin
      hk = 3'd0;
    end else if (he > 4'sd4) begin
      hk = 3'd4;
    end else begin
      hk = he[2:0];
    end
    hprod  = coef_q[t_q] * $signed({1'b0, win[hk]});
    hacc_d = hacc_q + HSUM_W'(hprod);
  end

  // output position and vertical read address
  logic [ROW_W-1:0]      orr, rr;
  logic [COL_W-1:0]      oc;
  logic signed [13:0]    rr_s;
  logic                  oc_end, or_end;
  logic [LINE_AW-1:0]    waddr, raddr;

  always_comb begin
    orr = ({1'b0, out_row_q} < eff_h) ? out_row_q : hm1[ROW_W-1:0];
    oc  = ({1'b0, out_col_q} < eff_w) ? out_col_q : wm1[COL_W-1:0];
    oc_end = ({1'b0, oc} == wm1);
    or_end = ({1'b0, orr} == hm1);
    rr_s = $signed({2'b00, orr}) + $signed({11'b0, t_q}) - 14'sd2;
    if (rr_s < 14'sd0) begin
      rr = '0;
    end else if (rr_s > $signed({1'b0, hm1})) begin
      rr = hm1[ROW_W-1:0];
    end else begin
      rr = rr_s[ROW_W-1:0];
    end
    raddr = LINE_AW'(mod_lines(rr)) * LINE_AW'(MAX_WIDTH) + LINE_AW'(oc);
    waddr = LINE_AW'(slot_q) * LINE_AW'(MAX_WIDTH) + LINE_AW'(hc_q);
  end

  // result readiness: clamped window of the next output has arrived
  logic [HEIGHT_W-1:0] tr_full;
  logic [WIDTH_W-1:0]  tc_full;
  logic [ROW_W-1:0]    tr;
  logic [COL_W-1:0]    tc;
  logic                rdy;

  always_comb begin
    tr_full = {1'b0, out_row_q} + HEIGHT_W'(eff_r);
    tc_full = {1'b0, out_col_q} + WIDTH_W'(eff_r);
    tr = (tr_full > hm1) ? hm1[ROW_W-1:0] : tr_full[ROW_W-1:0];
    tc = (tc_full > wm1) ? wm1[COL_W-1:0] : tc_full[COL_W-1:0];
    rdy = frame_done_q || (in_row_q > tr) || ((in_row_q == tr) && (in_col_q > tc));
  end

  // line store of horizontal sums
  logic [HSUM_W-1:0] mem_q [LINE_DEPTH];
  logic [HSUM_W-1:0] rdata_q;
  logic              mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= hacc_d;
    end
    rdata_q <= mem_q[raddr];
  end

  // vertical tap, rounding and saturation
  logic signed [VPROD_W-1:0] vprod;
  logic signed [VACC_W-1:0]  vacc_d, vsum;
  logic signed [25:0]        vq;
  logic                      vsat;
  logic signed [FILT_W-1:0]  vfilt;

  always_comb begin
    vprod  = coef_q[t_q] * $signed(rdata_q);
    vacc_d = vacc_q + VACC_W'(vprod);
    vsum   = vacc_d + (VACC_W'(1) <<< 19);
    vq     = vsum[VACC_W-1:20];
    if (vq > 26'sd524287) begin
      vfilt = 20'sd524287;
      vsat  = 1'b1;
    end else if (vq < -26'sd524288) begin
      vfilt = -20'sd524288;
      vsat  = 1'b1;
    end else begin
      vfilt = vq[FILT_W-1:0];
      vsat  = 1'b0;
    end
  end

  logic accept;
  assign accept = in_i.valid && in_i.ready;

  // next state and strobes
  always_comb begin
    state_d         = state_q;
    in_i.ready      = 1'b0;
    out_o.valid     = 1'b0;
    cell_ctrl.load  = 1'b0;
    cell_ctrl.shift = 1'b0;
    mem_we          = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (req_e'(in_i.req_type) == REQ_PIXEL) begin
            cell_ctrl.load  = (ic == '0);
            cell_ctrl.shift = (ic != '0);
            state_d = has_write ? S_HSUM : S_CHECK;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_HSUM: begin
        if (t_q == t_end) begin
          mem_we = 1'b1;
          if (hc_q == hc_hi_q) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        state_d = rdy ? S_VRD : S_IDLE;
      end
      S_VRD: begin
        state_d = S_VACC;
      end
      S_VACC: begin
        state_d = (t_q == t_end) ? S_LAST : S_VRD;
      end
      S_LAST: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          state_d = last_q ? S_IDLE : S_VRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // position counters and frame flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q     <= '0;
      in_col_q     <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      frame_done_q <= 1'b0;
      n_q          <= '0;
      limit_q      <= '0;
      last_q       <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            n_q <= '0;
            if (req_e'(in_i.req_type) == REQ_PIXEL) begin
              limit_q <= 2'd3;
              if (frame_start) begin
                out_row_q <= '0;
                out_col_q <= '0;
              end
              if (ic_end) begin
                in_col_q <= '0;
                if (ir_end) begin
                  in_row_q     <= '0;
                  frame_done_q <= 1'b1;
                end else begin
                  in_row_q     <= ir + 12'd1;
                  frame_done_q <= frame_start ? 1'b0 : frame_done_q;
                end
              end else begin
                in_col_q     <= ic + 10'd1;
                in_row_q     <= ir;
                frame_done_q <= frame_start ? 1'b0 : frame_done_q;
              end
            end else begin
              limit_q <= 2'd1;
            end
          end
        end
        S_VACC: begin
          if (t_q == t_end) begin
            n_q <= n_q + 2'd1;
            if (oc_end) begin
              out_col_q <= '0;
              if (or_end) begin
                out_row_q    <= '0;
                frame_done_q <= 1'b0;
              end else begin
                out_row_q <= orr + 12'd1;
              end
            end else begin
              out_col_q <= oc + 10'd1;
              out_row_q <= orr;
            end
          end
        end
        S_LAST: begin
          // counters already advanced, so readiness is for the next result
          last_q <= (n_q >= limit_q) || !rdy;
        end
        default: ;
      endcase
    end
  end

  // payload and accumulators
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        ic_q    <= ic;
        hc_q    <= hc_start;
        hc_hi_q <= hc_last;
        slot_q  <= mod_lines(ir);
        t_q     <= t_start;
        hacc_q  <= '0;
      end
      S_HSUM: begin
        if (t_q == t_end) begin
          hacc_q <= '0;
          t_q    <= t_start;
          hc_q   <= hc_q + 10'd1;
        end else begin
          hacc_q <= hacc_d;
          t_q    <= t_q + 3'd1;
        end
      end
      S_CHECK: begin
        t_q    <= t_start;
        vacc_q <= '0;
      end
      S_VACC: begin
        if (t_q == t_end) begin
          filt_q <= vfilt;
          sat_q  <= vsat;
          eof_q  <= oc_end && or_end;
        end else begin
          vacc_q <= vacc_d;
          t_q    <= t_q + 3'd1;
        end
      end
      S_OUT: begin
        t_q    <= t_start;
        vacc_q <= '0;
      end
      default: ;
    endcase
  end

  assign out_o.filtered     = filt_q;
  assign out_o.saturated    = sat_q;
  assign out_o.last_in_run  = last_q;
  assign out_o.end_of_frame = eof_q;

endmodule

// ----- hw/rtl/sc_cell.sv -----
module sc_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sc_pkg::cell_ctrl_t        ctrl_i,
  input  logic [sc_pkg::PIX_W-1:0]  px_i,
  input  logic [sc_pkg::PIX_W-1:0]  prev_i,
  output logic [sc_pkg::PIX_W-1:0]  pix_o
);
  import sc_pkg::*;

  logic [PIX_W-1:0] pix_q;

  // row start fills the whole window with the edge pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (ctrl_i.load) begin
      pix_q <= px_i;
    end else if (ctrl_i.shift) begin
      pix_q <= prev_i;
    end
  end

  assign pix_o = pix_q;
endmodule

// ----- bench/separable_conv_clamped_border_top_test.sv -----
module separable_conv_clamped_border_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sc_pkg::*;

  // quiet cycles before the run is declared hung
  localparam int WATCHDOG_LIMIT = 3000;
  // settle time after the last expected word, covers the slowest pixel word
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    req_e                  req;
    logic [PIX_W-1:0]      px;
  } in_word_t;

  typedef struct {
    logic signed [FILT_W-1:0] filt;
    bit                       sat;
    bit                       last;
    bit                       eof;
  } filt_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sc_in_if  in_ch ();
  sc_out_if out_ch ();

  separable_conv_clamped_border_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // clock: 20 ns period
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // -------------------------------------------------------------------------
  // convolution predictor: own copy of registers, window, line store, counters
  // -------------------------------------------------------------------------
  int unsigned     cf_rad, cf_w, cf_h;
  logic [15:0]     cf_coef [5];
  byte unsigned    pix_win [5];
  int              hsum_lines [5][MAX_WIDTH];
  int              in_row, in_col, out_row, out_col;
  bit              frame_done;

  filt_word_t      filt_expect_q [$];
  in_word_t        pixel_stream_q [$];
  int              mismatches;

  function automatic int eff_rad();
    return (cf_rad > 2) ? 2 : int'(cf_rad);
  endfunction

  function automatic int eff_w();
    if (cf_w == 0) return 1;
    return (cf_w > MAX_WIDTH) ? MAX_WIDTH : int'(cf_w);
  endfunction

  function automatic int eff_h();
    if (cf_h == 0) return 1;
    return (cf_h > 4096) ? 4096 : int'(cf_h);
  endfunction

  function automatic longint tap_of(int m);
    return longint'($signed(cf_coef[m + 2]));
  endfunction

  // horizontal sum centered at column hc, window newest pixel at column ic
  function automatic int row_sum(int ic, int hc, int r);
    longint acc;
    int     k;
    acc = 0;
    for (int m = -r; m <= r; m++) begin
      k = ic - hc - m;
      if (k < 0) k = 0;
      if (k > 4) k = 4;
      acc += tap_of(m) * longint'(pix_win[k]);
    end
    return int'(acc);
  endfunction

  task automatic take_pixel(logic [PIX_W-1:0] px);
    int w, h, r, ir, ic, slot, lo, hi;
    w = eff_w();
    h = eff_h();
    r = eff_rad();
    ir = (in_row < h) ? in_row : h - 1;
    ic = (in_col < w) ? in_col : w - 1;
    slot = ir % 5;
    // first pixel of a frame drops whatever is still pending
    if (in_row == 0 && in_col == 0) begin
      out_row = 0;
      out_col = 0;
      frame_done = 1'b0;
    end
    if (ic == 0) begin
      for (int k = 0; k < 5; k++) pix_win[k] = px;
    end else begin
      for (int k = 4; k > 0; k--) pix_win[k] = pix_win[k - 1];
      pix_win[0] = px;
    end
    lo = ic - r;
    if (ic == w - 1) begin
      // row end flushes the right border columns too
      if (lo < 0) lo = 0;
      hi = ic;
    end else begin
      hi = lo;
    end
    for (int hc = lo; hc <= hi; hc++)
      if (hc >= 0 && hc < MAX_WIDTH) hsum_lines[slot][hc] = row_sum(ic, hc, r);
    if (ic + 1 >= w) begin
      in_col = 0;
      if (ir + 1 >= h) begin
        in_row = 0;
        frame_done = 1'b1;
      end else begin
        in_row = ir + 1;
      end
    end else begin
      in_col = ic + 1;
      in_row = ir;
    end
  endtask

  function automatic bit window_complete();
    int tr, tc;
    if (frame_done) return 1'b1;
    tr = out_row + eff_rad();
    if (tr > eff_h() - 1) tr = eff_h() - 1;
    tc = out_col + eff_rad();
    if (tc > eff_w() - 1) tc = eff_w() - 1;
    return (in_row > tr) || (in_row == tr && in_col > tc);
  endfunction

  function automatic filt_word_t vertical_pass();
    filt_word_t res;
    int         w, h, r, orr, oc, rr;
    longint     acc, q;
    w = eff_w();
    h = eff_h();
    r = eff_rad();
    orr = (out_row < h) ? out_row : h - 1;
    oc = (out_col < w) ? out_col : w - 1;
    acc = 0;
    for (int m = -r; m <= r; m++) begin
      rr = orr + m;
      if (rr < 0) rr = 0;
      if (rr > h - 1) rr = h - 1;
      acc += tap_of(m) * longint'(hsum_lines[rr % 5][oc]);
    end
    // round half up to 8 fraction bits, then clip
    q = (acc + (longint'(1) << 19)) >>> 20;
    res.sat = 1'b0;
    res.eof = 1'b0;
    res.last = 1'b0;
    if (q > 524287) begin
      q = 524287;
      res.sat = 1'b1;
    end
    if (q < -524288) begin
      q = -524288;
      res.sat = 1'b1;
    end
    res.filt = q[FILT_W-1:0];
    if (oc + 1 >= w) begin
      out_col = 0;
      if (orr + 1 >= h) begin
        out_row = 0;
        frame_done = 1'b0;
        res.eof = 1'b1;
      end else begin
        out_row = orr + 1;
      end
    end else begin
      out_col = oc + 1;
      out_row = orr;
    end
    return res;
  endfunction

  task automatic predict_word(in_word_t word);
    filt_word_t run_q [$];
    int         limit;
    limit = 1;
    if (word.req == REQ_PIXEL) begin
      take_pixel(word.px);
      limit = 3;
    end
    while (run_q.size() < limit && window_complete()) run_q.push_back(vertical_pass());
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) filt_expect_q.push_back(run_q[i]);
  endtask

  // results still owed for a finished frame
  function automatic int frame_backlog();
    int orr, oc;
    if (!frame_done) return 0;
    orr = (out_row < eff_h()) ? out_row : eff_h() - 1;
    oc = (out_col < eff_w()) ? out_col : eff_w() - 1;
    return (eff_h() - 1 - orr) * eff_w() + (eff_w() - oc);
  endfunction

  // -------------------------------------------------------------------------
  // input driver: bursts of words with random gaps, fed from pixel_stream_q
  // -------------------------------------------------------------------------
  in_word_t drv_word;
  bit       drv_taken;
  int       burst_left;
  int       gap_left;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_PIXEL;
    in_ch.pixel = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_RADIUS;
    cfg_data = '0;
    drv_taken = 1'b0;
    burst_left = 1;
    gap_left = 0;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_ch.valid || drv_taken)) begin
      drv_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pixel_stream_q.size() > 0) begin
        drv_word = pixel_stream_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.req_type <= drv_word.req;
        in_ch.pixel <= drv_word.px;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          // a third of the bursts run back to back with no gap
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // receiver: ready pattern redrawn periodically, plus at least one long hold-off
  // -------------------------------------------------------------------------
  bit hold_request;
  int hold_left;
  int rx_mode;
  int rx_count;

  initial begin
    hold_request = 1'b0;
    hold_left = 0;
    rx_mode = 0;
    rx_count = 0;
  end

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
    end
    rx_count++;
    if (rx_count % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (rx_count % 4 == 0);
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // monitor, prediction on accepted words and watchdog
  // -------------------------------------------------------------------------
  int quiet_cycles;

  initial begin
    quiet_cycles = 0;
    mismatches = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        if (filt_expect_q.size() == 0) begin
          $error("unexpected result word filtered=%0d", out_ch.filtered);
          mismatches++;
        end else begin
          filt_word_t exp_w;
          exp_w = filt_expect_q.pop_front();
          if (out_ch.filtered !== exp_w.filt) begin
            $error("filtered expected %0d actual %0d", exp_w.filt, out_ch.filtered);
            mismatches++;
          end
          if (out_ch.saturated !== exp_w.sat) begin
            $error("saturated expected %0d actual %0d", exp_w.sat, out_ch.saturated);
            mismatches++;
          end
          if (out_ch.last_in_run !== exp_w.last) begin
            $error("last_in_run expected %0d actual %0d", exp_w.last, out_ch.last_in_run);
            mismatches++;
          end
          if (out_ch.end_of_frame !== exp_w.eof) begin
            $error("end_of_frame expected %0d actual %0d", exp_w.eof, out_ch.end_of_frame);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles = 0;
        drv_taken = 1'b1;
        predict_word(drv_word);
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // stimulus sequencing
  // -------------------------------------------------------------------------

  // wait until every queued word has been taken by the block
  task automatic wait_taken();
    do @(posedge clk_i); while (pixel_stream_q.size() > 0 || in_ch.valid);
  endtask

  // all results home and the block done with any word that gave none
  task automatic wait_idle();
    wait_taken();
    while (filt_expect_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      REG_RADIUS: cf_rad = 32'(val & 16'h3);
      REG_WIDTH:  cf_w = 32'(val & 16'h7FF);
      REG_HEIGHT: cf_h = 32'(val & 16'h1FFF);
      default:    cf_coef[3'(idx - REG_COEF0)] = val;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_kernel(int r, int w, int h, logic [15:0] c0, logic [15:0] c1,
                            logic [15:0] c2, logic [15:0] c3, logic [15:0] c4);
    wait_idle();
    write_reg(REG_RADIUS, CFG_DATA_W'(r));
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_COEF0, c0);
    write_reg(REG_COEF1, c1);
    write_reg(REG_COEF2, c2);
    write_reg(REG_COEF3, c3);
    write_reg(REG_COEF4, c4);
  endtask

  task automatic push_pixels(int n, int fixed_px);
    in_word_t word;
    for (int i = 0; i < n; i++) begin
      word.req = REQ_PIXEL;
      word.px = (fixed_px < 0) ? PIX_W'($urandom_range(0, 255)) : PIX_W'(fixed_px);
      pixel_stream_q.push_back(word);
    end
  endtask

  task automatic push_drains(int n);
    in_word_t word;
    for (int i = 0; i < n; i++) begin
      word.req = REQ_DRAIN;
      word.px = PIX_W'($urandom_range(0, 255));
      pixel_stream_q.push_back(word);
    end
  endtask

  // after the last pixel, release exactly what the frame still owes
  task automatic drain_frame();
    wait_taken();
    push_drains(frame_backlog());
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      1: return 16'($urandom_range(0, 8192));
      2: return 16'(-$urandom_range(0, 4096));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int random_pixels;
    int fw, fh, cut;
    in_word_t word;

    // power-up defaults of the block
    cf_rad = 1;
    cf_w = 1024;
    cf_h = 1024;
    cf_coef[0] = 16'd0;
    cf_coef[1] = 16'd4096;
    cf_coef[2] = 16'd8192;
    cf_coef[3] = 16'd4096;
    cf_coef[4] = 16'd0;
    for (int k = 0; k < 5; k++) pix_win[k] = 8'd0;
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
    frame_done = 1'b0;

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // default kernel, drains with nothing pending give no result
    set_kernel(1, 4, 3, 16'd0, 16'd4096, 16'd8192, 16'd4096, 16'd0);
    push_drains(2);
    word.req = REQ_PIXEL;
    word.px = 8'd0;
    pixel_stream_q.push_back(word);
    word.px = 8'd255;
    pixel_stream_q.push_back(word);
    push_pixels(10, -1);
    drain_frame();

    // largest positive and negative taps on white pixels both saturate high
    set_kernel(2, 5, 2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_pixels(10, 255);
    drain_frame();
    set_kernel(2, 5, 2, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_pixels(10, 255);
    drain_frame();

    // zero sizes taken as one pixel, radius zero
    set_kernel(0, 0, 0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0);
    push_pixels(1, -1);
    drain_frame();

    // radius above the maximum, new frame started before the drain is done
    set_kernel(3, 3, 2, 16'd1000, 16'hF000, 16'd9000, 16'd2000, 16'd300);
    push_pixels(6, -1);
    wait_taken();
    push_drains(1);
    push_pixels(6, -1);
    drain_frame();

    // height shrunk mid frame: row counter clamps onto the new last row
    set_kernel(1, 3, 8, 16'd0, 16'd4096, 16'd8192, 16'd4096, 16'd0);
    push_pixels(15, -1);
    wait_idle();
    write_reg(REG_HEIGHT, 16'd3);
    push_pixels(3, -1);
    drain_frame();

    // random frames with small sizes
    random_pixels = 0;
    while (random_pixels < 20) begin
      set_kernel($urandom_range(0, 3), $urandom_range(1, 8), $urandom_range(1, 6),
                 pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
      fw = eff_w();
      fh = eff_h();
      // the first frame and about one in ten of the rest face a long receiver hold-off
      if (random_pixels == 0 || $urandom_range(0, 9) == 0) hold_request = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        // stray drains in the middle of the frame
        cut = $urandom_range(0, fw * fh - 1);
        push_pixels(cut, -1);
        push_drains($urandom_range(1, 3));
        push_pixels(fw * fh - cut, -1);
      end else begin
        push_pixels(fw * fh, -1);
      end
      random_pixels += fw * fh;
      if ($urandom_range(0, 4) == 0) begin
        // part of the backlog, then a fresh frame throws the rest away
        wait_taken();
        push_drains($urandom_range(0, frame_backlog()));
        push_pixels(fw * fh, -1);
        random_pixels += fw * fh;
      end
      drain_frame();
    end

    wait_idle();
    if (mismatches == 0 && filt_expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- separable_conv_clamped_border_top.f -----
hw/rtl/sc_pkg.sv
hw/rtl/sc_in_if.sv
hw/rtl/sc_out_if.sv
hw/rtl/sc_cell.sv
hw/rtl/separable_conv_clamped_border_top.sv
bench/separable_conv_clamped_border_top_test.sv
